// ===== design/ic3_pkg.sv =====
// Shared types, register codes and defaults for the 3x3 convolution block.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none
package ic3_pkg;

  localparam int MAX_WIDTH_DEF      = 2048;
  localparam int LANES_DEF          = 4;
  localparam int COEF_FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL_MODE  = 2'd2;
  localparam logic [1:0] REG_CHANNELS     = 2'd3;

  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [1:0]  KERNEL_MODE_RST  = 2'd0;
  localparam logic [2:0]  CHANNELS_RST     = 3'd3;

  // kernel modes; any other code filters as Gaussian
  localparam logic [1:0] MODE_GAUSS   = 2'd0;
  localparam logic [1:0] MODE_SOBEL_X = 2'd1;
  localparam logic [1:0] MODE_SOBEL_Y = 2'd2;

  localparam logic [7:0] SAT_MAX = 8'd255;

  typedef struct packed {
    logic [7:0] sample0;
    logic [7:0] sample1;
    logic [7:0] sample2;
    logic [7:0] sample3;
    logic       start_of_frame;
  } in_t;

  typedef struct packed {
    logic [7:0]  result0;
    logic [7:0]  result1;
    logic [7:0]  result2;
    logic [7:0]  result3;
    logic [11:0] out_row;
    logic [10:0] out_column;
    logic        last_of_run;
  } out_t;

  // One input's worth of results: up to four pixels, in emit order.
  // Pixel 0 is (row-1,col-1), 1 is (row-1,col), 2 is (row,col-1), 3 is (row,col).
  typedef struct packed {
    logic [3:0]        flags;
    logic [3:0][31:0]  pix;
    logic [11:0]       row;
    logic [10:0]       col;
  } job_t;

endpackage
`default_nettype wire

// ===== design/ic3_linebuf.sv =====
// Two line stores (rows r-2 and r-1) with read-before-write forwarding.
// Depends on nothing but its parameters.
`default_nettype none
module ic3_linebuf #(
  parameter int MAX_WIDTH = 2048,
  parameter int AW        = 11
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_upper,
  input  wire logic [31:0]   wr_middle,
  output logic      [31:0]   upper,
  output logic      [31:0]   middle
);

  logic [31:0] upper_mem  [MAX_WIDTH];
  logic [31:0] middle_mem [MAX_WIDTH];
  logic [31:0] upper_rd, middle_rd, upper_fwd, middle_fwd;
  logic        fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_rd  <= upper_mem[rd_addr];
      middle_rd <= middle_mem[rd_addr];
    end
  end

  // same-address write in the read cycle: take the data being written
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd        <= wr_en && (wr_addr == rd_addr);
      upper_fwd  <= wr_upper;
      middle_fwd <= wr_middle;
    end
  end

  assign upper  = fwd ? upper_fwd  : upper_rd;
  assign middle = fwd ? middle_fwd : middle_rd;

endmodule
`default_nettype wire

// ===== design/ic3_lane.sv =====
// One channel lane: three-stage 3x3 Gaussian / Sobel filter on 8-bit samples.
// Depends on ic3_pkg for mode codes and the saturation limit.
`default_nettype none
module ic3_lane #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            adv,
  input  wire logic [1:0]      mode,
  input  wire logic [8:0][7:0] win,
  output logic      [7:0]      result
);

  localparam int F = COEF_FRAC_BITS;
  localparam longint unsigned CoefEdgeL = (626 * (64'd1 << F) + 5000) / 10000;
  localparam longint unsigned CoefSideL = (1250 * (64'd1 << F) + 5000) / 10000;
  localparam longint unsigned CoefMidL  = (2497 * (64'd1 << F) + 5000) / 10000;
  localparam logic [F-1:0] CoefEdge = CoefEdgeL[F-1:0];
  localparam logic [F-1:0] CoefSide = CoefSideL[F-1:0];
  localparam logic [F-1:0] CoefMid  = CoefMidL[F-1:0];

  // stage 1: group sums
  logic [9:0]         corners, sides;
  logic [7:0]         center;
  logic signed [10:0] gx, gy;
  // stage 2: products and magnitudes
  logic [F+9:0]       p_edge, p_side;
  logic [F+7:0]       p_mid;
  logic [9:0]         mag_x, mag_y;

  logic [9:0]    sx_pos, sx_neg, sy_pos, sy_neg;
  logic [F+10:0] g_sum;
  logic [10:0]   g_int;
  logic [9:0]    mag;

  always_comb begin
    sx_pos = 10'(win[0]) + {1'b0, win[3], 1'b0} + 10'(win[6]);
    sx_neg = 10'(win[2]) + {1'b0, win[5], 1'b0} + 10'(win[8]);
    sy_pos = 10'(win[0]) + {1'b0, win[1], 1'b0} + 10'(win[2]);
    sy_neg = 10'(win[6]) + {1'b0, win[7], 1'b0} + 10'(win[8]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      corners <= 10'(win[0]) + 10'(win[2]) + 10'(win[6]) + 10'(win[8]);
      sides   <= 10'(win[1]) + 10'(win[3]) + 10'(win[5]) + 10'(win[7]);
      center  <= win[4];
      gx      <= $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
      gy      <= $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_edge <= corners * CoefEdge;
      p_side <= sides * CoefSide;
      p_mid  <= center * CoefMid;
      mag_x  <= gx[10] ? 10'(-gx) : gx[9:0];
      mag_y  <= gy[10] ? 10'(-gy) : gy[9:0];
    end
  end

  always_comb begin
    g_sum = (F+11)'(p_edge) + (F+11)'(p_side) + (F+11)'(p_mid);
    g_int = g_sum[F+10:F];
    mag   = (mode == ic3_pkg::MODE_SOBEL_X) ? mag_x : mag_y;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (mode == ic3_pkg::MODE_SOBEL_X || mode == ic3_pkg::MODE_SOBEL_Y) begin
        result <= (mag > 10'(ic3_pkg::SAT_MAX)) ? ic3_pkg::SAT_MAX : mag[7:0];
      end else begin
        result <= (g_int > 11'(ic3_pkg::SAT_MAX)) ? ic3_pkg::SAT_MAX : g_int[7:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/ic3_merge.sv =====
// Result sequencer: unpacks one job of up to four pixels into result transfers.
// Depends on ic3_pkg for job_t and out_t.
`default_nettype none
module ic3_merge (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  input  wire ic3_pkg::job_t job,
  output logic               take,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ic3_pkg::out_t      out_data
);

  logic [3:0]       rem;
  logic [3:0][31:0] pix;
  logic [11:0]      row;
  logic [10:0]      col;
  logic [3:0]       pick, rem_left;
  logic             load;
  logic [31:0]      sel_pix;
  logic [11:0]      sel_row;
  logic [10:0]      sel_col;

  always_comb begin
    pick = rem & (~rem + 4'd1);
    load = (rem != 4'd0) && (!out_valid || out_ready);
    rem_left = load ? (rem & ~pick) : rem;
    take = (rem_left == 4'd0);
    case (pick)
      4'b0001: begin
        sel_pix = pix[0]; sel_row = row - 12'd1; sel_col = col - 11'd1;
      end
      4'b0010: begin
        sel_pix = pix[1]; sel_row = row - 12'd1; sel_col = col;
      end
      4'b0100: begin
        sel_pix = pix[2]; sel_row = row; sel_col = col - 11'd1;
      end
      default: begin
        sel_pix = pix[3]; sel_row = row; sel_col = col;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 4'd0;
    end else if (take) begin
      rem <= job_valid ? job.flags : 4'd0;
    end else begin
      rem <= rem_left;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix <= job.pix;
      row <= job.row;
      col <= job.col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.result0     <= sel_pix[7:0];
      out_data.result1     <= sel_pix[15:8];
      out_data.result2     <= sel_pix[23:16];
      out_data.result3     <= sel_pix[31:24];
      out_data.out_row     <= sel_row;
      out_data.out_column  <= sel_col;
      out_data.last_of_run <= (rem_left == 4'd0);
    end
  end

endmodule
`default_nettype wire

// ===== design/image_convolution_3x3.sv =====
// Streaming 3x3 convolution (Gaussian, Sobel-X, Sobel-Y) over four 8-bit lanes.
// Depends on ic3_pkg, ic3_linebuf, ic3_lane and ic3_merge.
//
// Pixels arrive in raster order, one transfer per clock at full rate; the
// first pixel of a frame carries start_of_frame. Each input transfer yields
// zero to four result transfers: (r-1,c-1), then (r-1,W-1) at the end of a
// row, and on the last row also (r,c-1) and (r,W-1). Interior pixels are
// filtered (Sobel as absolute value, saturated at 255); border pixels pass
// through. Lanes at or above channels_in_use read zero. The input is taken
// every cycle as long as no input yields more than one result and out_ready
// holds; an input that yields several results holds the input side until the
// single result register has taken the last of them. The path from input to
// result runs: line store read, window shift, three filter stages, result
// register. Line stores are two MAX_WIDTH x 32 memories with one read and
// one write per cycle; configuration must be written through cfg_we/cfg_index/
// cfg_data while the block is idle; the block itself does not enforce this.
`default_nettype none
module image_convolution_3x3 #(
  parameter int MAX_WIDTH      = ic3_pkg::MAX_WIDTH_DEF,
  parameter int LANES          = ic3_pkg::LANES_DEF,
  parameter int COEF_FRAC_BITS = ic3_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ic3_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ic3_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [11:0]   cfg_data
);

  localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int FW = (AW + 1 > 12) ? AW + 1 : 12;

  // configuration registers
  logic [11:0] frame_width, frame_height;
  logic [1:0]  kernel_mode;
  logic [2:0]  channels_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= ic3_pkg::FRAME_WIDTH_RST;
      frame_height    <= ic3_pkg::FRAME_HEIGHT_RST;
      kernel_mode     <= ic3_pkg::KERNEL_MODE_RST;
      channels_in_use <= ic3_pkg::CHANNELS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ic3_pkg::REG_FRAME_WIDTH:  frame_width     <= cfg_data;
        ic3_pkg::REG_FRAME_HEIGHT: frame_height    <= cfg_data;
        ic3_pkg::REG_KERNEL_MODE:  kernel_mode     <= cfg_data[1:0];
        ic3_pkg::REG_CHANNELS:     channels_in_use <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size and position; the counters may sit past the frame after
  // a size change, in which case they count as the last position.
  logic [FW-1:0] fw_ext, w_eff, wm1, col_ext;
  logic [11:0]   hm1, row_cnt, r_cur, row_base;
  logic [AW-1:0] col_cnt, c_cur, col_base;
  logic          accept, adv;

  always_comb begin
    fw_ext = FW'(frame_width);
    if (fw_ext < FW'(3)) begin
      w_eff = FW'(3);
    end else if (fw_ext > FW'(MAX_WIDTH)) begin
      w_eff = FW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    wm1 = w_eff - FW'(1);
    hm1 = (frame_height < 12'd3) ? 12'd2 : frame_height - 12'd1;
    row_base = in_data.start_of_frame ? 12'd0 : row_cnt;
    col_base = in_data.start_of_frame ? AW'(0) : col_cnt;
    r_cur = (row_base > hm1) ? hm1 : row_base;
    col_ext = FW'(col_base);
    c_cur = (col_ext > wm1) ? wm1[AW-1:0] : col_base;
  end

  logic c_first, c_last, r_first, r_last;
  assign c_first = (c_cur == AW'(0));
  assign c_last  = (FW'(c_cur) == wm1);
  assign r_first = (r_cur == 12'd0);
  assign r_last  = (r_cur == hm1);

  assign in_ready = adv;
  assign accept   = in_valid && adv;

  // advance the position on every transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= 12'd0;
      col_cnt <= AW'(0);
    end else if (accept) begin
      if (c_last) begin
        col_cnt <= AW'(0);
        row_cnt <= r_last ? 12'd0 : r_cur + 12'd1;
      end else begin
        col_cnt <= c_cur + AW'(1);
        row_cnt <= r_cur;
      end
    end
  end

  // stage 1: line store read, capture of the input pixel and its result flags
  logic          v1;
  logic [31:0]   pix1;
  logic [11:0]   r1;
  logic [AW-1:0] c1;
  logic [3:0]    flags1;
  logic          filt1;
  logic [31:0]   up1, mid1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix1   <= {in_data.sample3, in_data.sample2, in_data.sample1, in_data.sample0};
      r1     <= r_cur;
      c1     <= c_cur;
      flags1 <= {r_last && c_last, r_last && !c_first,
                 !r_first && c_last, !r_first && !c_first};
      filt1  <= (r_cur >= 12'd2) && (c_cur >= AW'(2));
    end
  end

  ic3_linebuf #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_linebuf (
    .clk       (clk),
    .rd_en     (adv),
    .rd_addr   (c_cur),
    .wr_en     (adv && v1),
    .wr_addr   (c1),
    .wr_upper  (mid1),
    .wr_middle (pix1),
    .upper     (up1),
    .middle    (mid1)
  );

  // stage 2: slide the window one column
  logic [8:0][31:0] win;
  logic             v2;
  logic [3:0]       flags2;
  logic             filt2;
  logic [11:0]      r2;
  logic [10:0]      c2;
  logic [31:0]      mid2, cur2;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (adv && v1) begin
      win <= {pix1, win[8], win[7], mid1, win[5], win[4], up1, win[2], win[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flags2 <= flags1;
      filt2  <= filt1;
      r2     <= r1;
      c2     <= 11'(c1);
      mid2   <= mid1;
      cur2   <= pix1;
    end
  end

  // stages 3 to 5: filter lanes, with the item's pixels carried alongside
  logic [3:0][7:0] filt_lane;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    if (i < LANES) begin : g_used
      logic [8:0][7:0] lane_win;
      for (genvar k = 0; k < 9; k++) begin : g_tap
        assign lane_win[k] = win[k][8*i +: 8];
      end
      ic3_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
      ) u_lane (
        .clk    (clk),
        .adv    (adv),
        .mode   (kernel_mode),
        .win    (lane_win),
        .result (filt_lane[i])
      );
    end else begin : g_unused
      assign filt_lane[i] = 8'd0;
    end
  end

  logic [2:0]       vp;
  logic [2:0][3:0]  flags_p;
  logic [2:0]       filt_p;
  logic [2:0][11:0] r_p;
  logic [2:0][10:0] c_p;
  logic [2:0][31:0] ctr_p, mid_p, w7_p, cur_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 3'd0;
    end else if (adv) begin
      vp <= {vp[1:0], v2};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flags_p <= {flags_p[1:0], flags2};
      filt_p  <= {filt_p[1:0], filt2};
      r_p     <= {r_p[1:0], r2};
      c_p     <= {c_p[1:0], c2};
      ctr_p   <= {ctr_p[1:0], win[4]};
      mid_p   <= {mid_p[1:0], mid2};
      w7_p    <= {w7_p[1:0], win[7]};
      cur_p   <= {cur_p[1:0], cur2};
    end
  end

  // merge lanes: choose filtered or raw pixel, drop unused channels
  logic [31:0]   lane_mask;
  ic3_pkg::job_t job;
  logic          take;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_mask[8*i +: 8] = ((3'(i) < channels_in_use) && (i < LANES)) ? 8'hFF : 8'h00;
    end
    job.flags  = flags_p[2];
    job.pix[0] = (filt_p[2] ? filt_lane : ctr_p[2]) & lane_mask;
    job.pix[1] = mid_p[2] & lane_mask;
    job.pix[2] = w7_p[2] & lane_mask;
    job.pix[3] = cur_p[2] & lane_mask;
    job.row    = r_p[2];
    job.col    = c_p[2];
  end

  // hold the whole pipeline while the sequencer still owes results
  assign adv = !vp[2] || take;

  ic3_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .job_valid (vp[2]),
    .job       (job),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // column never runs past the last position of the row
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> (FW'(col_cnt) <= $past(wm1)))
    else $error("column count past end of row");

  // last pixel of the frame wraps both counters
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && c_last && r_last |=> (row_cnt == 12'd0) && (col_cnt == AW'(0)))
    else $error("position did not wrap at end of frame");

  // a stalled pipeline keeps its last stage's flags
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vp[2] && !take |=> vp[2] && $stable(flags_p[2]))
    else $error("job lost while sequencer busy");

endmodule
`default_nettype wire

// ===== test/image_convolution_3x3_tb.sv =====
// Self-checking testbench for image_convolution_3x3: 3x3 Gaussian/Sobel filter
// over a raster pixel stream. Depends on ic3_pkg and the block's RTL only.
// A local pixel-level predictor builds expected results; a monitor compares them.
module image_convolution_3x3_tb;

  localparam int LINE_DEPTH = 2048;
  localparam int TIMEOUT_CYCLES = 600000;
  // Gaussian weights in Q16, rounded to nearest
  localparam longint G_EDGE = (626 * 65536 + 5000) / 10000;
  localparam longint G_SIDE = (1250 * 65536 + 5000) / 10000;
  localparam longint G_MID  = (2497 * 65536 + 5000) / 10000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ic3_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ic3_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = ic3_pkg::REG_FRAME_WIDTH;
  logic [11:0] cfg_data = '0;

  image_convolution_3x3 dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stimulus and scoreboard state
  ic3_pkg::in_t  pixel_queue[$];
  ic3_pkg::out_t expected_pixels[$];
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  logic in_taken = 1'b0;

  // Predictor state: its own copy of the line stores, window and counters
  logic [31:0] upper_store[LINE_DEPTH];
  logic [31:0] middle_store[LINE_DEPTH];
  logic [31:0] window_px[9];
  int unsigned row_pos = 0, col_pos = 0;
  int unsigned width_reg = ic3_pkg::FRAME_WIDTH_RST, height_reg = ic3_pkg::FRAME_HEIGHT_RST;
  logic [1:0]  mode_reg = ic3_pkg::KERNEL_MODE_RST;
  int unsigned lanes_reg = ic3_pkg::CHANNELS_RST;

  initial begin
    for (int i = 0; i < 9; i++) window_px[i] = '0;
  end

  function automatic logic [7:0] filtered_lane(int lane);
    int sum;
    longint gsum;
    int sx[9];
    int sy[9];
    int k[9];
    sum = 0;
    gsum = 0;
    sx = '{1, 0, -1, 2, 0, -2, 1, 0, -1};
    sy = '{1, 2, 1, 0, 0, 0, -1, -2, -1};
    if (mode_reg == ic3_pkg::MODE_SOBEL_X || mode_reg == ic3_pkg::MODE_SOBEL_Y) begin
      if (mode_reg == ic3_pkg::MODE_SOBEL_X) k = sx;
      else k = sy;
      for (int i = 0; i < 9; i++) sum += k[i] * int'(window_px[i][8*lane +: 8]);
      if (sum < 0) sum = -sum;
      return (sum > 255) ? ic3_pkg::SAT_MAX : 8'(sum);
    end
    // anything else, mode three included, filters as Gaussian
    for (int i = 0; i < 9; i++) begin
      if (i == 4) gsum += G_MID * window_px[i][8*lane +: 8];
      else if (i % 2 == 1) gsum += G_SIDE * window_px[i][8*lane +: 8];
      else gsum += G_EDGE * window_px[i][8*lane +: 8];
    end
    gsum = gsum >>> 16;
    return (gsum > 255) ? ic3_pkg::SAT_MAX : 8'(gsum);
  endfunction

  function automatic ic3_pkg::out_t pixel_result(logic [31:0] px, bit filt, int unsigned row,
                                                 int unsigned col);
    ic3_pkg::out_t o;
    logic [7:0] v[4];
    for (int lane = 0; lane < 4; lane++) begin
      v[lane] = 8'd0;
      if (lane < lanes_reg) v[lane] = filt ? filtered_lane(lane) : px[8*lane +: 8];
    end
    o.result0 = v[0];
    o.result1 = v[1];
    o.result2 = v[2];
    o.result3 = v[3];
    o.out_row = 12'(row);
    o.out_column = 11'(col);
    o.last_of_run = 1'b0;
    return o;
  endfunction

  // Advance the predictor by one accepted pixel and queue what it completes.
  task automatic predict_pixel(ic3_pkg::in_t x);
    int unsigned w, h, r, c;
    logic [31:0] cur, up, mid;
    ic3_pkg::out_t run[$];
    w = (width_reg < 3) ? 3 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
    h = (height_reg < 3) ? 3 : height_reg;
    if (x.start_of_frame) begin
      row_pos = 0;
      col_pos = 0;
    end
    // counts left past the frame by a size change clamp to the last position
    r = (row_pos > h - 1) ? h - 1 : row_pos;
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    cur = {x.sample3, x.sample2, x.sample1, x.sample0};
    up = upper_store[c];
    mid = middle_store[c];
    upper_store[c] = mid;
    middle_store[c] = cur;
    window_px[0] = window_px[1]; window_px[1] = window_px[2]; window_px[2] = up;
    window_px[3] = window_px[4]; window_px[4] = window_px[5]; window_px[5] = mid;
    window_px[6] = window_px[7]; window_px[7] = window_px[8]; window_px[8] = cur;
    if (r >= 1 && c >= 1)
      run.push_back(pixel_result(window_px[4], r >= 2 && c >= 2, r - 1, c - 1));
    if (r >= 1 && c == w - 1) run.push_back(pixel_result(mid, 1'b0, r - 1, c));
    if (r == h - 1) begin
      if (c >= 1) run.push_back(pixel_result(window_px[7], 1'b0, r, c - 1));
      if (c == w - 1) run.push_back(pixel_result(cur, 1'b0, r, c));
    end
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) expected_pixels.push_back(run[i]);
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // Monitor: sample both handshakes at the rising edge, check results in order.
  always @(posedge clk) begin
    ic3_pkg::out_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("[image_convolution_3x3] ERROR");
      $finish;
    end
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) predict_pixel(in_data);
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: row %0d col %0d", out_data.out_row,
                   out_data.out_column);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.result0 !== want.result0 || out_data.result1 !== want.result1 ||
            out_data.result2 !== want.result2 || out_data.result3 !== want.result3 ||
            out_data.out_row !== want.out_row || out_data.out_column !== want.out_column ||
            out_data.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp r%0d c%0d px %h %h %h %h last %b, got r%0d c%0d px %h %h %h %h last %b",
                     want.out_row, want.out_column, want.result0, want.result1,
                     want.result2, want.result3, want.last_of_run,
                     out_data.out_row, out_data.out_column, out_data.result0,
                     out_data.result1, out_data.result2, out_data.result3,
                     out_data.last_of_run);
        end
      end
    end
  end

  // Driver: change inputs on the falling edge; hold valid and payload until the transfer.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (!in_valid || in_taken) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_data <= pixel_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Wait until every pixel is sent and every result seen, then let the
  // pipeline empty out pixels that complete nothing.
  task automatic drain();
    while (pixel_queue.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ic3_pkg::REG_FRAME_WIDTH:  width_reg = val;
      ic3_pkg::REG_FRAME_HEIGHT: height_reg = val;
      ic3_pkg::REG_KERNEL_MODE:  mode_reg = val[1:0];
      default:                   lanes_reg = val[2:0];
    endcase
  endtask

  task automatic configure(int w, int h, logic [1:0] mode, int lanes);
    drain();
    write_reg(ic3_pkg::REG_FRAME_WIDTH, 12'(w));
    write_reg(ic3_pkg::REG_FRAME_HEIGHT, 12'(h));
    write_reg(ic3_pkg::REG_KERNEL_MODE, 12'(mode));
    write_reg(ic3_pkg::REG_CHANNELS, 12'(lanes));
  endtask

  function automatic logic [7:0] rand_sample();
    // favor the extremes so Sobel saturates and Gaussian hits its ceiling
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Queue a run of pixels; sof marks the first, noise adds stray frame starts.
  task automatic queue_pixels(int count, bit sof, bit noise);
    ic3_pkg::in_t p;
    for (int i = 0; i < count; i++) begin
      p.sample0 = rand_sample();
      p.sample1 = rand_sample();
      p.sample2 = rand_sample();
      p.sample3 = rand_sample();
      p.start_of_frame = (i == 0) ? sof : (noise && $urandom_range(49) == 0);
      pixel_queue.push_back(p);
    end
  endtask

  // Directed 3x3 frame of 0 and 255 (checkerboard, top row, left column, zero per lane), or all 255.
  task automatic queue_pattern(bit flat);
    ic3_pkg::in_t p;
    for (int i = 0; i < 9; i++) begin
      p.sample0 = (flat || i % 2 == 0) ? 8'd255 : 8'd0;
      p.sample1 = (flat || i < 3) ? 8'd255 : 8'd0;
      p.sample2 = (flat || i % 3 == 0) ? 8'd255 : 8'd0;
      p.sample3 = flat ? 8'd255 : 8'd0;
      p.start_of_frame = (i == 0);
      pixel_queue.push_back(p);
    end
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
      default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
    endcase
  endtask

  initial begin
    int w, h;
    int lane_choice[4];
    lane_choice = '{1, 0, 2, 7};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: smallest frame, each kernel, saturation on extremes
    configure(3, 3, ic3_pkg::MODE_SOBEL_X, 4);
    queue_pattern(1'b0);
    configure(3, 3, ic3_pkg::MODE_SOBEL_Y, 4);
    queue_pattern(1'b0);
    configure(3, 3, ic3_pkg::MODE_GAUSS, 4);
    queue_pattern(1'b1);

    // random frames over modes (mode three included) and lane counts
    for (int p = 0; p < 4; p++) begin
      w = $urandom_range(5, 3);
      h = $urandom_range(4, 3);
      configure(w, h, 2'(p % 4), lane_choice[p]);
      set_idling(p);
      queue_pixels(w * h, 1'b1, 1'b0);
      queue_pixels(w + $urandom_range(w), 1'b1, 1'b1);
    end

    // shrink the frame mid-way so the counters sit past the new edge
    configure(6, 5, ic3_pkg::MODE_SOBEL_X, 4);
    set_idling(3);
    queue_pixels(6 * 3 + 4, 1'b1, 1'b0);
    configure(4, 3, ic3_pkg::MODE_SOBEL_Y, 4);
    queue_pixels(10, 1'b0, 1'b0);

    // sizes below the minimum act as three
    configure(2, 1, ic3_pkg::MODE_GAUSS, 4);
    set_idling(1);
    queue_pixels(8, 1'b1, 1'b0);
    configure(0, 0, ic3_pkg::MODE_SOBEL_X, 3);
    queue_pixels(8, 1'b1, 1'b0);

    // tallest frame, a few rows only
    configure(3, 4095, ic3_pkg::MODE_SOBEL_Y, 4);
    set_idling(2);
    queue_pixels(10, 1'b1, 1'b0);

    // width beyond the line store clamps to its depth; first pixels only
    configure(4095, 3, ic3_pkg::MODE_GAUSS, 4);
    set_idling(0);
    queue_pixels(10, 1'b1, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    mismatches += expected_pixels.size();
    if (mismatches == 0)
      $display("[image_convolution_3x3] OK");
    else
      $display("[image_convolution_3x3] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/ic3_pkg.sv
design/ic3_linebuf.sv
design/ic3_lane.sv
design/ic3_merge.sv
design/image_convolution_3x3.sv
test/image_convolution_3x3_tb.sv
